FILE: rtl/core/scfl_pkg.sv
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared types and constants of the size-class free-list cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scfl_pkg;

  localparam int NUM_CLASSES = 32;
  localparam int STACK_DEPTH = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 40;
  localparam int BYTES_W = 41;
  localparam int ALIGN_W = 4;
  localparam int CMAX_W  = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int KEXT_W = CLS_W + 2;
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int MEM_AW = CLS_W + IDX_W;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_MAX  = 1'b1;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd6;
  localparam logic [CMAX_W-1:0]  CMAX_RESET  = 32'd1048576;

  typedef enum logic [2:0] {
    ST_ZERO      = 3'd0,
    ST_HIT       = 3'd1,
    ST_MISS      = 3'd2,
    ST_BYP_ALLOC = 3'd3,
    ST_CACHED    = 3'd4,
    ST_BYP_FREE  = 3'd5,
    ST_NULL      = 3'd6,
    ST_FULL      = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    OP_ZERO   = 3'd0,
    OP_BALLOC = 3'd1,
    OP_ALLOC  = 3'd2,
    OP_NULL   = 3'd3,
    OP_BFREE  = 3'd4,
    OP_FREE   = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CLS_W-1:0]   cls;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
  } cmd_t;

endpackage

FILE: rtl/core/scfl_front.sv
// ----------------------------------------------------------------------------
// scfl_front
// Request intake: registers a request, maps it to a size class or bypass and
// hands a classified command to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scfl_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type,
  input  logic [scfl_pkg::SIZE_W-1:0]    size_bytes,
  input  logic [scfl_pkg::ADDR_W-1:0]    block_addr,
  input  logic [scfl_pkg::ALIGN_W-1:0]   align_log2,
  input  logic [scfl_pkg::CMAX_W-1:0]    cache_max_bytes,
  input  logic                           q_full,
  output logic                           q_push,
  output scfl_pkg::cmd_t                 q_data
);
  import scfl_pkg::*;

  logic                s1_valid;
  logic                s1_free;
  logic [SIZE_W-1:0]   s1_size;
  logic [ADDR_W-1:0]   s1_addr;
  logic                s1_big;
  logic                s1_zero;
  logic                accept;

  logic [CMAX_W-1:0]   sm1;
  logic [KEXT_W-1:0]   blen;
  logic [KEXT_W-1:0]   kcls;
  logic                byp;
  logic [BYTES_W-1:0]  mask;
  logic [BYTES_W-1:0]  pad;

  assign busy   = s1_valid && q_full;
  assign accept = start && !busy;
  assign q_push = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_free <= req_type;
      s1_size <= size_bytes;
      s1_addr <= block_addr;
      s1_big  <= size_bytes > {{(SIZE_W-CMAX_W){1'b0}}, cache_max_bytes};
      s1_zero <= size_bytes == '0;
    end
  end

  // bit length of size-1 gives the smallest power of two covering size
  always_comb begin
    sm1  = s1_size[CMAX_W-1:0] - CMAX_W'(1);
    blen = '0;
    for (int i = 0; i < CMAX_W; i++) begin
      if (sm1[i]) begin
        blen = KEXT_W'(i + 1);
      end
    end
    if (s1_zero) begin
      blen = '0;
    end
    kcls = (blen < KEXT_W'(align_log2)) ? KEXT_W'(align_log2) : blen;
    byp  = s1_big || (kcls >= KEXT_W'(NUM_CLASSES));
    mask = (BYTES_W'(1) << align_log2) - BYTES_W'(1);
    pad  = ({1'b0, s1_size} + mask) & ~mask;
  end

  always_comb begin
    q_data.cls   = kcls[CLS_W-1:0];
    q_data.addr  = s1_addr;
    q_data.bytes = '0;
    if (!s1_free) begin
      if (s1_zero) begin
        q_data.op = OP_ZERO;
      end else if (byp) begin
        q_data.op    = OP_BALLOC;
        q_data.bytes = pad;
      end else begin
        q_data.op    = OP_ALLOC;
        q_data.bytes = BYTES_W'(1) << kcls;
      end
    end else begin
      if (s1_addr == '0) begin
        q_data.op = OP_NULL;
      end else if (byp) begin
        q_data.op = OP_BFREE;
      end else begin
        q_data.op = OP_FREE;
      end
    end
  end

endmodule

FILE: rtl/core/scfl_queue.sv
// ----------------------------------------------------------------------------
// scfl_queue
// Short command queue between request intake and stack execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scfl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scfl_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output scfl_pkg::cmd_t head
);
  import scfl_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue pop while empty");

endmodule

FILE: rtl/core/scfl_back.sv
// ----------------------------------------------------------------------------
// scfl_back
// Stack execution: per-class counts and the block address store, pops on
// allocate hits, pushes on frees while the class stack has room, and drives the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scfl_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  scfl_pkg::cmd_t                q_head,
  output logic                          q_pop,
  output logic                          done,
  output logic [2:0]                    status,
  output logic [scfl_pkg::ADDR_W-1:0]   result_addr,
  output logic [scfl_pkg::BYTES_W-1:0]  alloc_bytes
);
  import scfl_pkg::*;

  logic [ADDR_W-1:0]  stacks [NUM_CLASSES * STACK_DEPTH];
  logic [CNT_W-1:0]   counts [NUM_CLASSES];

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic               wr_en;
  logic               rd_en;
  logic [MEM_AW-1:0]  mem_addr;
  status_t            st_next;
  logic [ADDR_W-1:0]  addr_next;
  logic [BYTES_W-1:0] bytes_next;

  logic               hit;
  status_t            st;
  logic [ADDR_W-1:0]  addr_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ADDR_W-1:0]  mem_q;

  assign q_pop = !q_empty;
  assign cnt   = counts[q_head.cls];

  always_comb begin
    cnt_next   = cnt;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    mem_addr   = {q_head.cls, cnt[IDX_W-1:0]};
    addr_next  = '0;
    bytes_next = '0;
    case (q_head.op)
      OP_ZERO: begin
        st_next = ST_ZERO;
      end
      OP_BALLOC: begin
        st_next    = ST_BYP_ALLOC;
        bytes_next = q_head.bytes;
      end
      OP_ALLOC: begin
        if (cnt != '0) begin
          st_next  = ST_HIT;
          cnt_next = cnt - CNT_W'(1);
          rd_en    = q_pop;
          mem_addr = {q_head.cls, cnt_next[IDX_W-1:0]};
        end else begin
          st_next    = ST_MISS;
          bytes_next = q_head.bytes;
        end
      end
      OP_NULL: begin
        st_next = ST_NULL;
      end
      OP_BFREE: begin
        st_next   = ST_BYP_FREE;
        addr_next = q_head.addr;
      end
      OP_FREE: begin
        if (cnt >= CNT_W'(STACK_DEPTH)) begin
          st_next   = ST_FULL;
          addr_next = q_head.addr;
        end else begin
          st_next  = ST_CACHED;
          cnt_next = cnt + CNT_W'(1);
          wr_en    = q_pop;
        end
      end
      default: begin
        st_next = ST_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
      done <= 1'b0;
    end else begin
      if (q_pop) begin
        counts[q_head.cls] <= cnt_next;
      end
      done <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stacks[mem_addr] <= q_head.addr;
    end
    if (rd_en) begin
      mem_q <= stacks[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      st      <= st_next;
      hit     <= st_next == ST_HIT;
      addr_q  <= addr_next;
      bytes_q <= bytes_next;
    end
  end

  assign status      = st;
  assign result_addr = hit ? mem_q : addr_q;
  assign alloc_bytes = bytes_q;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> cnt <= CNT_W'(STACK_DEPTH))
    else $error("class count beyond stack depth");

  a_hit_from_count: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.op == OP_ALLOC && cnt != '0) |=> (done && status == ST_HIT))
    else $error("cached allocate did not report a hit");

  a_done_follows_pop: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(q_pop))
    else $error("result without an executed command");

endmodule

FILE: rtl/core/size_class_free_list_cache.sv
// ----------------------------------------------------------------------------
// size_class_free_list_cache
// Size-class free-list cache for a power-of-two segregated allocator.
//
// A request (req_type, size_bytes, block_addr) is taken at a rising edge with
// start high and busy low. Every request yields exactly one result: status,
// result_addr and alloc_bytes are valid for the single cycle in which done
// is high, in request order; the receiver cannot hold results off.
// A request passes the intake register (size compare, class encode, padding
// add), then sits at the queue head while execution looks up the class count
// and does the registered read or write of the address store, and then sets
// the result registers and done.
// Throughput is one request per cycle; execution drains the queue every
// cycle, so the queue never fills and busy stays low.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx (0 align_log2,
// 1 cache_max_bytes) at once; write only while no request is in flight.
// Reset empties every class stack and the queue, and restores align_log2 to
// 6 and cache_max_bytes to 1 MiB. Reset is synchronous.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module size_class_free_list_cache (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [scfl_pkg::SIZE_W-1:0]     size_bytes,
  input  logic [scfl_pkg::ADDR_W-1:0]     block_addr,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [scfl_pkg::ADDR_W-1:0]     result_addr,
  output logic [scfl_pkg::BYTES_W-1:0]    alloc_bytes,
  input  logic                            cfg_we,
  input  logic [scfl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [scfl_pkg::CFG_W-1:0]      cfg_wdata
);
  import scfl_pkg::*;

  logic [ALIGN_W-1:0] align_log2;
  logic [CMAX_W-1:0]  cache_max_bytes;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      align_log2      <= ALIGN_RESET;
      cache_max_bytes <= CMAX_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ALIGN_LOG2: align_log2      <= cfg_wdata[ALIGN_W-1:0];
        REG_CACHE_MAX:  cache_max_bytes <= cfg_wdata[CMAX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scfl_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .size_bytes      (size_bytes),
    .block_addr      (block_addr),
    .align_log2      (align_log2),
    .cache_max_bytes (cache_max_bytes),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  scfl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  scfl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .done        (done),
    .status      (status),
    .result_addr (result_addr),
    .alloc_bytes (alloc_bytes)
  );

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for size_class_free_list_cache. Directed requests hit
// zero sizes, null frees, misses, hits, bypass padding at the top of the size
// range and a class stack filled past its depth. After that, random
// allocate/free traffic runs over several alignment and cache-limit settings,
// including alignments outside the nominal range and a limit that pushes
// sizes past the last class. A scoreboard class keeps its own copy of the
// class stacks and checks every result, field by field, in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import scfl_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 60;
  localparam logic [ALIGN_W-1:0] ALIGN_PLAN [PHASES] = '{4'd3, 4'd12, 4'd0, 4'd15, 4'd6, 4'd9};
  localparam logic [CMAX_W-1:0] CMAX_PLAN [PHASES] =
    '{32'h8000_0000, 32'd1, 32'd4096, 32'hFFFF_FFFF, 32'd1048576, 32'd700};
  localparam int FREE_PLAN [PHASES] = '{50, 70, 45, 75, 55, 65};

  typedef struct {
    status_t            status;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
  } outcome_t;

  class alloc_scoreboard;
    logic [ALIGN_W-1:0] align_log2;
    logic [CMAX_W-1:0]  cache_max;
    logic [ADDR_W-1:0]  stacks [NUM_CLASSES][STACK_DEPTH];
    int unsigned        depth_of [NUM_CLASSES];
    outcome_t           outcomes_due [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        status_seen [8];

    function new();
      align_log2 = ALIGN_RESET;
      cache_max = CMAX_RESET;
      mismatches = 0;
      checked = 0;
      foreach (depth_of[i]) depth_of[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_ALIGN_LOG2) align_log2 = data[ALIGN_W-1:0];
      else cache_max = data[CMAX_W-1:0];
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction

    function void note_request(logic free_req, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] addr);
      outcome_t    o;
      int          k;
      logic        bypass;
      logic [63:0] unit;
      o.status = ST_ZERO;
      o.addr = '0;
      o.bytes = '0;
      k = 0;
      bypass = (size > cache_max);
      if (!bypass) begin
        while (k < 63 && (64'd1 << k) < 64'(size)) k++;
        if (k < int'(align_log2)) k = int'(align_log2);
        if (k >= NUM_CLASSES) bypass = 1'b1;
      end
      if (!free_req) begin
        if (size == '0) begin
          o.status = ST_ZERO;
        end else if (bypass) begin
          unit = 64'd1 << align_log2;
          o.status = ST_BYP_ALLOC;
          o.bytes = BYTES_W'((64'(size) + unit - 64'd1) & ~(unit - 64'd1));
        end else if (depth_of[k] > 0) begin
          depth_of[k]--;
          o.status = ST_HIT;
          o.addr = stacks[k][depth_of[k]];
        end else begin
          o.status = ST_MISS;
          o.bytes = BYTES_W'(64'd1 << k);
        end
      end else begin
        if (addr == '0) begin
          o.status = ST_NULL;
        end else if (bypass) begin
          o.status = ST_BYP_FREE;
          o.addr = addr;
        end else if (depth_of[k] >= STACK_DEPTH) begin
          o.status = ST_FULL;
          o.addr = addr;
        end else begin
          stacks[k][depth_of[k]] = addr;
          depth_of[k]++;
          o.status = ST_CACHED;
        end
      end
      outcomes_due = {outcomes_due, o};
    endfunction

    function void check_result(logic [2:0] st, logic [ADDR_W-1:0] ra,
                               logic [BYTES_W-1:0] ab);
      outcome_t o;
      if (outcomes_due.size() == 0) begin
        $error("result with no request outstanding: status %0d addr %h bytes %h", st, ra, ab);
        mismatches++;
        return;
      end
      o = outcomes_due.pop_front();
      checked++;
      status_seen[o.status]++;
      if (st !== o.status) begin
        $error("status mismatch: expected %0d, got %0d", o.status, st);
        mismatches++;
      end
      if (ra !== o.addr) begin
        $error("result_addr mismatch: expected %h, got %h", o.addr, ra);
        mismatches++;
      end
      if (ab !== o.bytes) begin
        $error("alloc_bytes mismatch: expected %h, got %h", o.bytes, ab);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 req_type = 1'b0;
  logic [SIZE_W-1:0]    size_bytes = '0;
  logic [ADDR_W-1:0]    block_addr = '0;
  logic                 done;
  logic [2:0]           status;
  logic [ADDR_W-1:0]    result_addr;
  logic [BYTES_W-1:0]   alloc_bytes;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_ALIGN_LOG2;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int unsigned          cycles = 0;
  int unsigned          sent = 0;
  alloc_scoreboard      sb = new();

  size_class_free_list_cache DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .size_bytes  (size_bytes),
    .block_addr  (block_addr),
    .done        (done),
    .status      (status),
    .result_addr (result_addr),
    .alloc_bytes (alloc_bytes),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("** size_class_free_list_cache: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst && done) sb.check_result(status, result_addr, alloc_bytes);
  end

  function automatic int idle_gap(int quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet != 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(input logic rt, input logic [SIZE_W-1:0] sz,
                      input logic [ADDR_W-1:0] ad, input int gap);
    logic stalled;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rt;
    size_bytes <= sz;
    block_addr <= ad;
    do begin
      @(negedge clk);
      stalled = (busy !== 1'b0);
      @(posedge clk);
    end while (stalled);
    sb.note_request(rt, sz, ad);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_regs(input logic [ALIGN_W-1:0] al, input logic [CMAX_W-1:0] cm);
    cfg_we <= 1'b1;
    cfg_idx <= REG_ALIGN_LOG2;
    cfg_wdata <= CFG_W'(al);
    @(posedge clk);
    cfg_idx <= REG_CACHE_MAX;
    cfg_wdata <= CFG_W'(cm);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_ALIGN_LOG2, CFG_W'(al));
    sb.write_reg(REG_CACHE_MAX, CFG_W'(cm));
  endtask

  // Mostly requests into a few hot classes so stacks fill and drain.
  task automatic random_request(input int free_pct, output logic rt,
                                output logic [SIZE_W-1:0] sz, output logic [ADDR_W-1:0] ad);
    int          r;
    int          k;
    logic [63:0] span;
    r = $urandom_range(0, 99);
    rt = ($urandom_range(0, 99) < free_pct);
    ad = ADDR_W'({$urandom, $urandom});
    if (ad == '0) ad = ADDR_W'(1);
    if (r < 80) begin
      k = int'(sb.align_log2) + $urandom_range(0, 3);
      if (k > NUM_CLASSES - 1) k = NUM_CLASSES - 1;
      if (k == 0) begin
        sz = SIZE_W'(1);
      end else begin
        span = 64'd1 << (k - 1);
        sz = SIZE_W'(span + 64'd1 + ({$urandom, $urandom} % span));
      end
      if (sz > sb.cache_max) sz = SIZE_W'(64'd1 + ({$urandom, $urandom} % 64'(sb.cache_max)));
      if (rt && $urandom_range(0, 9) == 0) sz = '0;
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0: sz = SIZE_W'(sb.cache_max);
        1: sz = SIZE_W'(64'(sb.cache_max) + 64'd1);
        2: sz = '1;
        default: sz = SIZE_W'({$urandom, $urandom});
      endcase
    end else if (r < 95) begin
      sz = '0;
    end else begin
      rt = 1'b1;
      ad = '0;
      sz = SIZE_W'({$urandom, $urandom});
    end
  endtask

  initial begin
    logic              rt;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] ad;
    int                i;
    int                p;
    int                n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send(1'b0, '0, 48'h0000_0000_1234, 0);
    send(1'b1, 40'd100, '0, 0);
    send(1'b1, '0, '0, 0);
    send(1'b0, 40'd1, '0, idle_gap(0));
    send(1'b1, '0, 48'h0000_0000_1000, 0);
    send(1'b0, 40'd64, '0, 0);
    send(1'b0, 40'd65, '0, 0);
    send(1'b0, 40'd1048576, '0, 0);
    send(1'b0, 40'd1048577, '0, 0);
    send(1'b0, '1, '0, 0);
    send(1'b1, '1, '1, 0);
    for (i = 0; i < STACK_DEPTH + 1; i++) begin
      send(1'b1, 40'd200, ADDR_W'(48'h8000_0000_0000 | (i + 1)), idle_gap(0));
    end

    for (p = 0; p < PHASES; p++) begin
      drain();
      write_regs(ALIGN_PLAN[p], CMAX_PLAN[p]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        random_request(FREE_PLAN[p], rt, sz, ad);
        send(rt, sz, ad, idle_gap(int'(p % 3 == 2)));
        if (!(rt && ad == '0)) n++;
      end
    end
    drain();

    $display("covered %0d transactions over %0d register settings, align_log2 0 to 15",
             sent, PHASES + 1);
    $display("hit %0d, miss %0d, cached %0d, stack full %0d, bypass %0d/%0d, zero %0d, null %0d",
             sb.status_seen[ST_HIT], sb.status_seen[ST_MISS], sb.status_seen[ST_CACHED],
             sb.status_seen[ST_FULL], sb.status_seen[ST_BYP_ALLOC], sb.status_seen[ST_BYP_FREE],
             sb.status_seen[ST_ZERO], sb.status_seen[ST_NULL]);
    if (sb.mismatches == 0) begin
      $display("** size_class_free_list_cache: PASSED **");
    end else begin
      $display("** size_class_free_list_cache: FAILED **");
    end
    $finish;
  end

endmodule
